// ----- rtl/ptps_pkg.sv -----
// Package with shared types, constants and the arctangent table of the pointing block.
package ptps_pkg;

  localparam int unsigned CordicSteps = 14;
  localparam int unsigned StepW = $clog2(CordicSteps + 1);
  localparam int unsigned CordW = 50;
  localparam int unsigned ZW = 34;
  localparam int unsigned AngleW = 16;
  localparam int unsigned CmpW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = 1;

  typedef enum logic [1:0] {
    ReqInit = 2'd0,
    ReqGoto = 2'd1,
    ReqBad2 = 2'd2,
    ReqBad3 = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPanSlope   = 3'd0,
    CfgPanOffset  = 3'd1,
    CfgTiltSlope  = 3'd2,
    CfgTiltOffset = 3'd3,
    CfgStartPan   = 3'd4,
    CfgStartTilt  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OpError = 2'd0,
    OpInit  = 2'd1,
    OpGoto  = 2'd2
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [15:0] x_arg;
    logic signed [15:0] y_arg;
  } work_t;

  function automatic logic [ZW-1:0] atan_entry(input logic [4:0] i);
    logic [ZW-1:0] r;
    begin
      case (i)
        5'd0: r = 34'd843314857;
        5'd1: r = 34'd497837829;
        5'd2: r = 34'd263043837;
        5'd3: r = 34'd133525159;
        5'd4: r = 34'd67021687;
        5'd5: r = 34'd33543516;
        5'd6: r = 34'd16775851;
        5'd7: r = 34'd8388437;
        5'd8: r = 34'd4194283;
        5'd9: r = 34'd2097149;
        5'd10: r = 34'd1048576;
        5'd11: r = 34'd524288;
        5'd12: r = 34'd262144;
        5'd13: r = 34'd131072;
        5'd14: r = 34'd65536;
        5'd15: r = 34'd32768;
        5'd16: r = 34'd16384;
        5'd17: r = 34'd8192;
        5'd18: r = 34'd4096;
        5'd19: r = 34'd2048;
        5'd20: r = 34'd1024;
        5'd21: r = 34'd512;
        5'd22: r = 34'd256;
        5'd23: r = 34'd128;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- rtl/ptps_front.sv -----
// Front end that accepts requests, tracks the ready flag and queues classified work.
module ptps_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_stall_o,
  input  logic [1:0]          req_type_i,
  input  logic signed [15:0]  point_x_i,
  input  logic signed [14:0]  point_y_i,
  output logic                work_valid_o,
  input  logic                work_pop_i,
  output ptps_pkg::work_t     work_o
);

  ptps_pkg::work_t q_mem_q [ptps_pkg::QueueDepth];
  logic [ptps_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [ptps_pkg::QueuePtrW:0] count_q;
  logic ready_q;
  logic push;
  ptps_pkg::work_t item;

  assign req_stall_o = (count_q == (ptps_pkg::QueuePtrW + 1)'(ptps_pkg::QueueDepth));
  assign push = req_valid_i && !req_stall_o;
  assign work_valid_o = (count_q != '0);
  assign work_o = q_mem_q[rd_ptr_q];

  always_comb begin
    item.x_arg = point_x_i;
    item.y_arg = 16'(signed'(point_y_i)) + 16'sd8192;
    case (ptps_pkg::req_e'(req_type_i))
      ptps_pkg::ReqInit: item.op = ptps_pkg::OpInit;
      ptps_pkg::ReqGoto: item.op = ready_q ? ptps_pkg::OpGoto : ptps_pkg::OpError;
      default: item.op = ptps_pkg::OpError;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
      ready_q <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
        if (ptps_pkg::req_e'(req_type_i) == ptps_pkg::ReqInit) begin
          ready_q <= 1'b1;
        end
      end
      if (work_pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (push ? 1'b1 : 1'b0) - (work_pop_i ? 1'b1 : 1'b0);
    end
  end

endmodule

// ----- rtl/ptps_back.sv -----
// Back end with a shared CORDIC, compare mapping and the output register.
module ptps_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ptps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ptps_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                        work_valid_i,
  output logic                        work_pop_o,
  input  ptps_pkg::work_t             work_i,
  output logic                        rsp_valid_o,
  input  logic                        rsp_stall_i,
  output logic                        status_o,
  output logic                        drive_valid_o,
  output logic [15:0]                 pan_compare_o,
  output logic [15:0]                 tilt_compare_o,
  output logic                        driver_init_o,
  output logic signed [15:0]          pan_angle_now_o,
  output logic signed [15:0]          tilt_angle_now_o
);

  typedef enum logic [2:0] {
    StIdle, StCordic, StMul, StMap, StOut
  } state_e;

  state_e state_q;
  logic signed [31:0] pan_slope_q, tilt_slope_q;
  logic signed [23:0] pan_off_q, tilt_off_q;
  logic signed [15:0] start_pan_q, start_tilt_q;
  logic signed [15:0] pan_store_q, tilt_store_q;
  logic signed [15:0] tilt_arg_q;
  logic signed [ptps_pkg::CordW-1:0] cx_q, cy_q;
  logic signed [ptps_pkg::ZW-1:0] cz_q;
  logic [ptps_pkg::StepW-1:0] step_q;
  logic second_q;
  logic signed [47:0] prod_q;
  logic signed [15:0] ang_sel;
  logic signed [31:0] slope_sel;
  logic signed [23:0] off_sel;
  logic signed [ptps_pkg::CordW-1:0] dx, dy;
  logic signed [ptps_pkg::ZW-1:0] at, z_rnd;
  logic signed [15:0] z_q14;
  logic signed [26:0] shifted;
  logic signed [27:0] cmp_sum;
  logic [15:0] cmp_sat;
  logic [15:0] pan_cmp_q;

  assign dx = cy_q >>> step_q;
  assign dy = cx_q >>> step_q;
  assign at = ptps_pkg::atan_entry(5'(step_q));
  assign z_rnd = cz_q + ptps_pkg::ZW'(32768);
  assign z_q14 = z_rnd[31:16];
  assign ang_sel = second_q ? tilt_store_q : pan_store_q;
  assign slope_sel = second_q ? tilt_slope_q : pan_slope_q;
  assign off_sel = second_q ? tilt_off_q : pan_off_q;
  assign shifted = 27'((prod_q + 48'sd2097152) >>> 22);
  assign cmp_sum = 28'(shifted) + 28'(off_sel);
  assign cmp_sat = cmp_sum < 0 ? 16'd0 : (cmp_sum > 28'sd65535 ? 16'hFFFF : cmp_sum[15:0]);
  assign work_pop_o = (state_q == StIdle) && work_valid_i;
  assign rsp_valid_o = (state_q == StOut);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_slope_q <= '0;
      tilt_slope_q <= '0;
      pan_off_q <= '0;
      tilt_off_q <= '0;
      start_pan_q <= '0;
      start_tilt_q <= '0;
    end else if (cfg_we_i) begin
      case (ptps_pkg::cfg_idx_e'(cfg_idx_i))
        ptps_pkg::CfgPanSlope: pan_slope_q <= cfg_data_i;
        ptps_pkg::CfgPanOffset: pan_off_q <= cfg_data_i[23:0];
        ptps_pkg::CfgTiltSlope: tilt_slope_q <= cfg_data_i;
        ptps_pkg::CfgTiltOffset: tilt_off_q <= cfg_data_i[23:0];
        ptps_pkg::CfgStartPan: start_pan_q <= cfg_data_i[15:0];
        ptps_pkg::CfgStartTilt: start_tilt_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pan_store_q <= '0;
      tilt_store_q <= '0;
      status_o <= 1'b0;
      drive_valid_o <= 1'b0;
      driver_init_o <= 1'b0;
      pan_compare_o <= '0;
      tilt_compare_o <= '0;
      pan_angle_now_o <= '0;
      tilt_angle_now_o <= '0;
      step_q <= '0;
      second_q <= 1'b0;
      cx_q <= '0;
      cy_q <= '0;
      cz_q <= '0;
      tilt_arg_q <= '0;
      prod_q <= '0;
      pan_cmp_q <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (work_valid_i) begin
            status_o <= 1'b0;
            drive_valid_o <= 1'b0;
            driver_init_o <= 1'b0;
            pan_compare_o <= '0;
            tilt_compare_o <= '0;
            case (work_i.op)
              ptps_pkg::OpInit: begin
                pan_store_q <= start_pan_q;
                tilt_store_q <= start_tilt_q;
                pan_angle_now_o <= start_pan_q;
                tilt_angle_now_o <= start_tilt_q;
                driver_init_o <= 1'b1;
                state_q <= StOut;
              end
              ptps_pkg::OpGoto: begin
                cx_q <= ptps_pkg::CordW'(64'sd1073741824);
                cy_q <= ptps_pkg::CordW'(work_i.x_arg) <<< 16;
                cz_q <= '0;
                step_q <= '0;
                second_q <= 1'b0;
                tilt_arg_q <= work_i.y_arg;
                state_q <= StCordic;
              end
              default: begin
                status_o <= 1'b1;
                pan_angle_now_o <= pan_store_q;
                tilt_angle_now_o <= tilt_store_q;
                state_q <= StOut;
              end
            endcase
          end
        end
        StCordic: begin
          if (step_q == ptps_pkg::StepW'(ptps_pkg::CordicSteps)) begin
            if (!second_q) begin
              pan_store_q <= z_q14;
              cx_q <= ptps_pkg::CordW'(64'sd1073741824);
              cy_q <= ptps_pkg::CordW'(tilt_arg_q) <<< 16;
              cz_q <= '0;
              step_q <= '0;
              second_q <= 1'b1;
            end else begin
              tilt_store_q <= z_q14;
              second_q <= 1'b0;
              state_q <= StMul;
            end
          end else begin
            if (!cy_q[ptps_pkg::CordW-1]) begin
              cx_q <= cx_q + dx;
              cy_q <= cy_q - dy;
              cz_q <= cz_q + at;
            end else begin
              cx_q <= cx_q - dx;
              cy_q <= cy_q + dy;
              cz_q <= cz_q - at;
            end
            step_q <= step_q + 1'b1;
          end
        end
        StMul: begin
          prod_q <= 48'(slope_sel) * 48'(ang_sel);
          state_q <= StMap;
        end
        StMap: begin
          if (!second_q) begin
            pan_cmp_q <= cmp_sat;
            second_q <= 1'b1;
            state_q <= StMul;
          end else begin
            second_q <= 1'b0;
            pan_compare_o <= pan_cmp_q;
            tilt_compare_o <= cmp_sat;
            drive_valid_o <= 1'b1;
            pan_angle_now_o <= pan_store_q;
            tilt_angle_now_o <= tilt_store_q;
            state_q <= StOut;
          end
        end
        StOut: begin
          if (!rsp_stall_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ----- rtl/pan_tilt_point_to_servo_pwm.sv -----
// Top level of the pan-tilt pointing block.
//  channel | direction | handshake
//  req     | in        | req_valid_i / req_stall_o
//  rsp     | out       | rsp_valid_o / rsp_stall_i
//  cfg     | in        | cfg_we_i, no back-pressure
// An init or error request goes straight to the response; a goto first runs through
// two 14-step passes of the single shared CORDIC and the shared multiplier.
// Reset clears configuration, stored angles and the ready flag.
// A two-entry queue keeps taking requests while the back end works or is stalled, until it is full.
module pan_tilt_point_to_servo_pwm (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_stall_o,
  input  logic [1:0]                  req_type_i,
  input  logic signed [15:0]          point_x_i,
  input  logic signed [14:0]          point_y_i,
  output logic                        rsp_valid_o,
  input  logic                        rsp_stall_i,
  output logic                        status_o,
  output logic                        drive_valid_o,
  output logic [15:0]                 pan_compare_o,
  output logic [15:0]                 tilt_compare_o,
  output logic                        driver_init_o,
  output logic signed [15:0]          pan_angle_now_o,
  output logic signed [15:0]          tilt_angle_now_o,
  input  logic                        cfg_we_i,
  input  logic [ptps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ptps_pkg::CfgDataW-1:0] cfg_data_i
);

  logic work_valid, work_pop;
  ptps_pkg::work_t work;

  ptps_front u_front (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .req_type_i, .point_x_i, .point_y_i,
    .work_valid_o(work_valid), .work_pop_i(work_pop), .work_o(work)
  );

  ptps_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .work_valid_i(work_valid), .work_pop_o(work_pop), .work_i(work),
    .rsp_valid_o, .rsp_stall_i, .status_o, .drive_valid_o, .pan_compare_o,
    .tilt_compare_o, .driver_init_o, .pan_angle_now_o, .tilt_angle_now_o
  );

endmodule

// ----- rtl/ptps_checker.sv -----
// Port-level checker for the pointing block and its bind.
module ptps_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic rsp_valid_o,
  input logic rsp_stall_i,
  input logic status_o,
  input logic drive_valid_o,
  input logic driver_init_o,
  input logic [15:0] pan_compare_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(pan_compare_o))
    else $error("stalled response changed");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $onehot0({status_o, drive_valid_o, driver_init_o}))
    else $error("response flags conflict");
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && status_o |-> pan_compare_o == 16'd0)
    else $error("error response carries a compare");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_stall_i |=> !rsp_valid_o)
    else $error("response repeated");

endmodule

bind pan_tilt_point_to_servo_pwm ptps_checker u_checker (
  .clk_i, .rst_ni, .rsp_valid_o, .rsp_stall_i, .status_o, .drive_valid_o,
  .driver_init_o, .pan_compare_o
);

// ----- bench/tb.sv -----
// Self-checking testbench for the pan-tilt pointing block with a built-in predictor.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [1:0]         rtype;
    logic signed [15:0] px;
    logic signed [14:0] py;
  } request_t;

  typedef struct packed {
    logic        status;
    logic        drive_valid;
    logic [15:0] pan_cmp;
    logic [15:0] tilt_cmp;
    logic        drv_init;
    logic [15:0] pan_ang;
    logic [15:0] tilt_ang;
  } servo_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_stall_o;
  logic [1:0] req_type_i = '0;
  logic signed [15:0] point_x_i = '0;
  logic signed [14:0] point_y_i = '0;
  logic rsp_valid_o;
  logic rsp_stall_i = 1'b0;
  logic status_o, drive_valid_o, driver_init_o;
  logic [15:0] pan_compare_o, tilt_compare_o;
  logic signed [15:0] pan_angle_now_o, tilt_angle_now_o;
  logic cfg_we_i = 1'b0;
  logic [ptps_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [ptps_pkg::CfgDataW-1:0] cfg_data_i = '0;

  request_t pending_reqs[$];
  servo_cmd_t expected_cmds[$];
  int unsigned fail_count = 0;
  int unsigned calm_cycles = 0;
  int unsigned hold_cycles = 0;

  logic signed [31:0] pan_slope_r, tilt_slope_r;
  logic signed [23:0] pan_off_r, tilt_off_r;
  logic signed [15:0] start_pan_r, start_tilt_r;
  logic ready_q;
  logic [15:0] pan_store, tilt_store;

  always #4 clk_i = ~clk_i;

  pan_tilt_point_to_servo_pwm dut (.*);

  function automatic longint atan_rom(int i);
    longint t[24] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
                      262144, 131072, 65536, 32768, 16384, 8192,
                      4096, 2048, 1024, 512, 256, 128};
    return t[i];
  endfunction

  function automatic longint cordic_atan(longint arg);
    longint cx, cy, cz, dx, dy;
    cx = 64'sd1 << 30;
    cy = arg * 65536;
    cz = 0;
    for (int i = 0; i < ptps_pkg::CordicSteps && i < 24; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; cz += atan_rom(i);
      end else begin
        cx -= dx; cy += dy; cz -= atan_rom(i);
      end
    end
    return (cz + 32768) >>> 16;
  endfunction

  function automatic logic [15:0] angle_to_compare(longint ang, logic signed [31:0] slope,
                                                   logic signed [23:0] off);
    longint c;
    c = longint'(off) + ((longint'(slope) * ang + (64'sd1 << 21)) >>> 22);
    if (c < 0) return 16'd0;
    if (c > 65535) return 16'hFFFF;
    return c[15:0];
  endfunction

  function automatic servo_cmd_t predict_servo(request_t r);
    servo_cmd_t e;
    longint pan, tilt;
    e = '0;
    e.status = 1'b1;
    if (r.rtype == ptps_pkg::ReqInit) begin
      pan_store = start_pan_r;
      tilt_store = start_tilt_r;
      ready_q = 1'b1;
      e.status = 1'b0;
      e.drv_init = 1'b1;
    end else if (r.rtype == ptps_pkg::ReqGoto && ready_q) begin
      pan = cordic_atan(longint'(r.px));
      tilt = cordic_atan(longint'(r.py) + 8192);
      pan_store = pan[15:0];
      tilt_store = tilt[15:0];
      e.pan_cmp = angle_to_compare(pan, pan_slope_r, pan_off_r);
      e.tilt_cmp = angle_to_compare(tilt, tilt_slope_r, tilt_off_r);
      e.status = 1'b0;
      e.drive_valid = 1'b1;
    end
    e.pan_ang = pan_store;
    e.tilt_ang = tilt_store;
    return e;
  endfunction

  always @(posedge clk_i) begin
    if (req_valid_i && !req_stall_o) begin
      expected_cmds.push_back(predict_servo(pending_reqs.pop_front()));
    end
    if (pending_reqs.size() > 0 && (calm_cycles > 0 || $urandom_range(99) >= 18)) begin
      req_valid_i <= 1'b1;
      req_type_i <= pending_reqs[0].rtype;
      point_x_i <= pending_reqs[0].px;
      point_y_i <= pending_reqs[0].py;
    end else if (!(req_valid_i && req_stall_o)) begin
      req_valid_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    servo_cmd_t e;
    if (rsp_valid_o && !rsp_stall_i) begin
      if (expected_cmds.size() == 0) begin
        $error("unexpected response");
        fail_count++;
      end else begin
        e = expected_cmds.pop_front();
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); fail_count++;
        end
        if (drive_valid_o !== e.drive_valid) begin
          $error("drive_valid exp %0d got %0d", e.drive_valid, drive_valid_o); fail_count++;
        end
        if (pan_compare_o !== e.pan_cmp) begin
          $error("pan_compare exp %0d got %0d", e.pan_cmp, pan_compare_o); fail_count++;
        end
        if (tilt_compare_o !== e.tilt_cmp) begin
          $error("tilt_compare exp %0d got %0d", e.tilt_cmp, tilt_compare_o); fail_count++;
        end
        if (driver_init_o !== e.drv_init) begin
          $error("driver_init exp %0d got %0d", e.drv_init, driver_init_o); fail_count++;
        end
        if (pan_angle_now_o !== e.pan_ang) begin
          $error("pan_angle_now exp %0d got %0d", e.pan_ang, pan_angle_now_o); fail_count++;
        end
        if (tilt_angle_now_o !== e.tilt_ang) begin
          $error("tilt_angle_now exp %0d got %0d", e.tilt_ang, tilt_angle_now_o); fail_count++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp_stall_i <= 1'b1;
    end else begin
      rsp_stall_i <= (calm_cycles == 0) && ($urandom_range(99) < 18);
    end
    if (calm_cycles > 0) calm_cycles <= calm_cycles - 1;
  end

  task automatic write_reg(ptps_pkg::cfg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ptps_pkg::CfgPanSlope:   pan_slope_r = val;
      ptps_pkg::CfgPanOffset:  pan_off_r = val[23:0];
      ptps_pkg::CfgTiltSlope:  tilt_slope_r = val;
      ptps_pkg::CfgTiltOffset: tilt_off_r = val[23:0];
      ptps_pkg::CfgStartPan:   start_pan_r = val[15:0];
      default:                 start_tilt_r = val[15:0];
    endcase
  endtask

  task automatic queue_req(logic [1:0] t, logic [15:0] x, logic [14:0] y);
    pending_reqs.push_back('{t, x, y});
  endtask

  task automatic drain;
    while (pending_reqs.size() > 0 || expected_cmds.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_x();
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return 16'sd16384;
      2: return -16'sd16384;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic logic [14:0] rand_y();
    case ($urandom_range(5))
      0: return 15'($urandom);
      1: return 15'sd8192;
      2: return -15'sd8192;
      default: return 15'($signed($urandom_range(16384)) - 8192);
    endcase
  endfunction

  task automatic random_phase(int unsigned n);
    int unsigned k;
    repeat (n) begin
      k = $urandom_range(99);
      if (k < 8) queue_req(ptps_pkg::ReqInit, 16'($urandom), 15'($urandom));
      else if (k < 14) queue_req(2'($urandom_range(3, 2)), rand_x(), rand_y());
      else queue_req(ptps_pkg::ReqGoto, rand_x(), rand_y());
    end
  endtask

  initial begin
    pan_slope_r = '0; tilt_slope_r = '0; pan_off_r = '0; tilt_off_r = '0;
    start_pan_r = '0; start_tilt_r = '0;
    ready_q = 1'b0; pan_store = '0; tilt_store = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_req(ptps_pkg::ReqGoto, 16'sd100, 15'sd0);
    queue_req(ptps_pkg::ReqBad2, '0, '0);
    queue_req(ptps_pkg::ReqBad3, '1, '1);
    drain();
    write_reg(ptps_pkg::CfgPanSlope, 32'sd64000 * 256 / 3);
    write_reg(ptps_pkg::CfgPanOffset, 32'sd3000);
    write_reg(ptps_pkg::CfgTiltSlope, -32'sd5000000);
    write_reg(ptps_pkg::CfgTiltOffset, 32'sd4500);
    write_reg(ptps_pkg::CfgStartPan, 16'sd25736);
    write_reg(ptps_pkg::CfgStartTilt, -16'sd25736);
    queue_req(ptps_pkg::ReqInit, '0, '0);
    queue_req(ptps_pkg::ReqGoto, 16'sd16384, 15'sd8192);
    queue_req(ptps_pkg::ReqGoto, -16'sd16384, -15'sd8192);
    queue_req(ptps_pkg::ReqGoto, 16'sd0, 15'sd0);
    queue_req(ptps_pkg::ReqGoto, 16'h7FFF, 15'h3FFF);
    queue_req(ptps_pkg::ReqGoto, 16'h8000, 15'h4000);
    queue_req(ptps_pkg::ReqGoto, 16'hFFFF, 15'h7FFF);
    queue_req(ptps_pkg::ReqBad2, 16'sd5, 15'sd5);
    queue_req(ptps_pkg::ReqBad3, 16'sd5, 15'sd5);
    queue_req(ptps_pkg::ReqInit, '1, '1);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(ptps_pkg::CfgPanSlope, 32'h7FFFFFFF);
          write_reg(ptps_pkg::CfgPanOffset, 32'h007FFFFF);
          write_reg(ptps_pkg::CfgTiltSlope, 32'h80000000);
          write_reg(ptps_pkg::CfgTiltOffset, 32'h00800000);
        end
        1: begin
          write_reg(ptps_pkg::CfgPanSlope, 32'h80000000);
          write_reg(ptps_pkg::CfgPanOffset, 32'h00800000);
          write_reg(ptps_pkg::CfgTiltSlope, 32'h7FFFFFFF);
          write_reg(ptps_pkg::CfgTiltOffset, 32'h007FFFFF);
        end
        default: begin
          write_reg(ptps_pkg::CfgPanSlope,
                    32'($signed($urandom_range(40000000)) - 20000000));
          write_reg(ptps_pkg::CfgPanOffset, 32'($urandom_range(65535)));
          write_reg(ptps_pkg::CfgTiltSlope,
                    32'($signed($urandom_range(40000000)) - 20000000));
          write_reg(ptps_pkg::CfgTiltOffset, 32'($urandom_range(65535)));
        end
      endcase
      write_reg(ptps_pkg::CfgStartPan, 16'($signed($urandom_range(51472)) - 25736));
      write_reg(ptps_pkg::CfgStartTilt, 16'($signed($urandom_range(51472)) - 25736));
      if (ph == 2) begin
        calm_cycles = 3000;
        hold_cycles = 400;
      end
      random_phase(340);
      drain();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
